// File: rtl/hrsa_pkg.sv
package hrsa_pkg;

  // setpoint, limit, delay, step, address and data widths
  localparam int TEMP_W = 10;
  localparam int DELAY_W = 8;
  localparam int STEP_W = 7;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_SP_FLOOR = 3'd0;
  localparam logic [2:0] REG_SP_CEIL = 3'd1;
  localparam logic [2:0] REG_REPEAT_DELAY = 3'd2;
  localparam logic [2:0] REG_STEP_SIZE = 3'd3;
  localparam logic [2:0] REG_INIT_SETPOINT = 3'd4;

  // register reset values
  localparam logic [TEMP_W-1:0] RST_SP_FLOOR = TEMP_W'(150);
  localparam logic [TEMP_W-1:0] RST_SP_CEIL = TEMP_W'(450);
  localparam logic [DELAY_W-1:0] RST_REPEAT_DELAY = DELAY_W'(150);
  localparam logic [STEP_W-1:0] RST_STEP_SIZE = STEP_W'(10);
  localparam logic [TEMP_W-1:0] RST_INIT_SETPOINT = TEMP_W'(300);

endpackage

// File: rtl/hold_repeat_setpoint_adjuster_unit.sv
// hold-to-repeat setpoint adjuster
// input channel: one request per button tick (in_up_pressed, in_down_pressed),
//   handshake in_valid / in_stall; a request is taken when in_valid is high
//   and in_stall is low
// result channel: one result per request (out_setpoint and the three strobes
//   out_content_changed, out_integrator_reset, out_pid_off), out_valid /
//   out_stall
// output: the result is in the output register in the cycle after the request
//   is taken; throughput is one request per cycle unless stalled, set by the
//   single state update (fsm, hold timer, saturating add) between in/out regs
// stall: in_stall rises only while a result waits and out_stall is high; a
//   result that leaves in the same cycle frees the slot for the next request
// configuration: apb write/read of setpoint floor, setpoint ceiling,
//   repeat delay, step size, initial setpoint at byte addresses 0, 4, 8, 12,
//   16; writing the initial setpoint also loads the setpoint at once; write
//   only while idle
// reset: rst_n (synchronous, active low) loads the register defaults, puts
//   the fsm in idle, clears the hold timer, sets the setpoint to 300 and
//   empties the output register
module hold_repeat_setpoint_adjuster_unit
  import hrsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_up_pressed,
  input  logic              in_down_pressed,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TEMP_W-1:0] out_setpoint,
  output logic              out_content_changed,
  output logic              out_integrator_reset,
  output logic              out_pid_off,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_UP_ARMED = 3'd1,
    ST_UP_STEP  = 3'd2,
    ST_LOCK     = 3'd3,
    ST_DN_ARMED = 3'd4,
    ST_DN_STEP  = 3'd5
  } state_t;

  state_t              state_r, state_nxt;
  logic [DELAY_W-1:0]  timer_r, timer_nxt, timer_mid;
  logic [TEMP_W-1:0]   setpoint_r, setpoint_nxt;
  logic [TEMP_W-1:0]   sp_floor_r, sp_ceil_r, init_setpoint_r;
  logic [DELAY_W-1:0]  repeat_delay_r;
  logic [STEP_W-1:0]   step_size_r;
  logic                out_valid_r;
  logic [TEMP_W-1:0]   out_setpoint_r;
  logic                out_changed_r, out_ireset_r, out_pidoff_r;
  logic                changed, ireset, pidoff;
  logic                in_take, cfg_wr;
  logic [2:0]          cfg_idx;
  logic [TEMP_W:0]     sum_up, floor_dn;

  // handshake
  assign in_stall = out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = paddr[4:2];
  assign pready   = 1'b1;

  // register read
  always_comb begin
    case (cfg_idx)
      REG_SP_FLOOR:      prdata = DATA_W'(sp_floor_r);
      REG_SP_CEIL:       prdata = DATA_W'(sp_ceil_r);
      REG_REPEAT_DELAY:  prdata = DATA_W'(repeat_delay_r);
      REG_STEP_SIZE:     prdata = DATA_W'(step_size_r);
      REG_INIT_SETPOINT: prdata = DATA_W'(init_setpoint_r);
      default:           prdata = '0;
    endcase
  end

  // saturation compares
  assign sum_up   = (TEMP_W+1)'(setpoint_r) + (TEMP_W+1)'(step_size_r);
  assign floor_dn = (TEMP_W+1)'(sp_floor_r) + (TEMP_W+1)'(step_size_r);

  // per-tick state update
  always_comb begin
    state_nxt    = state_r;
    timer_mid    = timer_r;
    setpoint_nxt = setpoint_r;
    changed      = 1'b0;
    ireset       = 1'b0;
    pidoff       = 1'b0;
    case (state_r)
      ST_UP_ARMED: begin
        if (!in_up_pressed) state_nxt = ST_IDLE;
        else if (in_down_pressed) state_nxt = ST_LOCK;
        else if (timer_r == '0) state_nxt = ST_UP_STEP;
      end
      ST_UP_STEP: begin
        if (sum_up > (TEMP_W+1)'(sp_ceil_r)) setpoint_nxt = sp_ceil_r;
        else setpoint_nxt = sum_up[TEMP_W-1:0];
        changed   = 1'b1;
        ireset    = 1'b1;
        timer_mid = repeat_delay_r;
        state_nxt = ST_UP_ARMED;
      end
      ST_LOCK: begin
        if (!in_up_pressed && !in_down_pressed) state_nxt = ST_IDLE;
      end
      ST_DN_ARMED: begin
        if (!in_down_pressed) state_nxt = ST_IDLE;
        else if (in_up_pressed) state_nxt = ST_LOCK;
        else if (timer_r == '0) state_nxt = ST_DN_STEP;
      end
      ST_DN_STEP: begin
        if ((TEMP_W+1)'(setpoint_r) < floor_dn) setpoint_nxt = sp_floor_r;
        else setpoint_nxt = setpoint_r - TEMP_W'(step_size_r);
        changed   = 1'b1;
        ireset    = 1'b1;
        pidoff    = 1'b1;
        timer_mid = repeat_delay_r;
        state_nxt = ST_DN_ARMED;
      end
      default: begin
        // idle and unused codes
        if (in_up_pressed) begin
          timer_mid = repeat_delay_r;
          state_nxt = ST_UP_ARMED;
        end else if (in_down_pressed) begin
          timer_mid = repeat_delay_r;
          state_nxt = ST_DN_ARMED;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
    // timer counts down after the state update
    timer_nxt = (timer_mid != '0) ? timer_mid - DELAY_W'(1) : timer_mid;
  end

  // state, configuration and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      timer_r         <= '0;
      setpoint_r      <= RST_INIT_SETPOINT;
      sp_floor_r      <= RST_SP_FLOOR;
      sp_ceil_r       <= RST_SP_CEIL;
      repeat_delay_r  <= RST_REPEAT_DELAY;
      step_size_r     <= RST_STEP_SIZE;
      init_setpoint_r <= RST_INIT_SETPOINT;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_take) begin
        state_r        <= state_nxt;
        timer_r        <= timer_nxt;
        setpoint_r     <= setpoint_nxt;
        out_setpoint_r <= setpoint_nxt;
        out_changed_r  <= changed;
        out_ireset_r   <= ireset;
        out_pidoff_r   <= pidoff;
        out_valid_r    <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (cfg_idx)
          REG_SP_FLOOR:      sp_floor_r <= pwdata[TEMP_W-1:0];
          REG_SP_CEIL:       sp_ceil_r <= pwdata[TEMP_W-1:0];
          REG_REPEAT_DELAY:  repeat_delay_r <= pwdata[DELAY_W-1:0];
          REG_STEP_SIZE:     step_size_r <= pwdata[STEP_W-1:0];
          REG_INIT_SETPOINT: begin
            init_setpoint_r <= pwdata[TEMP_W-1:0];
            setpoint_r      <= pwdata[TEMP_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_setpoint         = out_setpoint_r;
  assign out_content_changed  = out_changed_r;
  assign out_integrator_reset = out_ireset_r;
  assign out_pid_off          = out_pidoff_r;

endmodule

// File: sim/hold_repeat_setpoint_adjuster_unit_test.sv
module hold_repeat_setpoint_adjuster_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hrsa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE = 4;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_UP_ARMED = 3'd1,
    ST_UP_STEP  = 3'd2,
    ST_LOCK     = 3'd3,
    ST_DN_ARMED = 3'd4,
    ST_DN_STEP  = 3'd5
  } btn_state_t;

  typedef struct packed {
    logic       up;
    logic       dn;
    logic [3:0] gap;
  } tick_req_t;

  typedef struct packed {
    logic [TEMP_W-1:0] setpoint;
    logic              changed;
    logic              ireset;
    logic              pidoff;
  } tick_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_up_pressed = 1'b0;
  logic              in_down_pressed = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [TEMP_W-1:0] out_setpoint;
  logic              out_content_changed;
  logic              out_integrator_reset;
  logic              out_pid_off;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor copy of the registers and the button state
  logic [TEMP_W-1:0]  lim_lo = RST_SP_FLOOR;
  logic [TEMP_W-1:0]  lim_hi = RST_SP_CEIL;
  logic [DELAY_W-1:0] rpt_delay = RST_REPEAT_DELAY;
  logic [STEP_W-1:0]  step_amt = RST_STEP_SIZE;
  logic [TEMP_W-1:0]  sp_init = RST_INIT_SETPOINT;
  btn_state_t         btn_state = ST_IDLE;
  logic [DELAY_W-1:0] hold_cnt = '0;
  logic [TEMP_W-1:0]  sp = RST_INIT_SETPOINT;

  tick_req_t tick_q[$];
  tick_res_t predicted[$];
  tick_req_t next_req;
  bit        have_next = 1'b0;
  int        wait_cnt = 0;
  int        stall_left = 0;
  int        reqs_queued = 0;
  int        reqs_taken = 0;
  int        results_seen = 0;
  int        steps_seen = 0;
  int        settings_cnt = 0;
  int        errors = 0;
  int        cycle_cnt = 0;
  bit        rx_calm = 1'b0;
  bit        hold_go = 1'b0;
  logic      rx_hold = 1'b0;

  hold_repeat_setpoint_adjuster_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_up_pressed        (in_up_pressed),
    .in_down_pressed      (in_down_pressed),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_setpoint         (out_setpoint),
    .out_content_changed  (out_content_changed),
    .out_integrator_reset (out_integrator_reset),
    .out_pid_off          (out_pid_off),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one button tick: state update, saturating step, then timer countdown
  function automatic tick_res_t tick_setpoint(input logic up, input logic dn);
    tick_res_t r;
    r = '0;
    case (btn_state)
      ST_UP_ARMED: begin
        if (!up) btn_state = ST_IDLE;
        else if (dn) btn_state = ST_LOCK;
        else if (hold_cnt == '0) btn_state = ST_UP_STEP;
      end
      ST_UP_STEP: begin
        if (int'(sp) + int'(step_amt) > int'(lim_hi)) sp = lim_hi;
        else sp = sp + TEMP_W'(step_amt);
        r.changed = 1'b1;
        r.ireset = 1'b1;
        hold_cnt = rpt_delay;
        btn_state = ST_UP_ARMED;
      end
      ST_LOCK: begin
        if (!up && !dn) btn_state = ST_IDLE;
      end
      ST_DN_ARMED: begin
        if (!dn) btn_state = ST_IDLE;
        else if (up) btn_state = ST_LOCK;
        else if (hold_cnt == '0) btn_state = ST_DN_STEP;
      end
      ST_DN_STEP: begin
        if (int'(sp) < int'(lim_lo) + int'(step_amt)) sp = lim_lo;
        else sp = sp - TEMP_W'(step_amt);
        r.changed = 1'b1;
        r.ireset = 1'b1;
        r.pidoff = 1'b1;
        hold_cnt = rpt_delay;
        btn_state = ST_DN_ARMED;
      end
      default: begin
        // up wins when both are pressed from idle
        if (up) begin
          hold_cnt = rpt_delay;
          btn_state = ST_UP_ARMED;
        end else if (dn) begin
          hold_cnt = rpt_delay;
          btn_state = ST_DN_ARMED;
        end else begin
          btn_state = ST_IDLE;
        end
      end
    endcase
    if (hold_cnt != '0) hold_cnt = hold_cnt - DELAY_W'(1);
    r.setpoint = sp;
    return r;
  endfunction

  // mirror of a register write
  function automatic void load_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    case (idx)
      REG_SP_FLOOR:      lim_lo = val[TEMP_W-1:0];
      REG_SP_CEIL:       lim_hi = val[TEMP_W-1:0];
      REG_REPEAT_DELAY:  rpt_delay = val[DELAY_W-1:0];
      REG_STEP_SIZE:     step_amt = val[STEP_W-1:0];
      REG_INIT_SETPOINT: begin
        sp_init = val[TEMP_W-1:0];
        sp = sp_init;
      end
      default: ;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    tick_res_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        res = tick_setpoint(in_up_pressed, in_down_pressed);
        predicted.push_back(res);
        reqs_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (!have_next && tick_q.size() != 0) begin
          next_req = tick_q.pop_front();
          have_next = 1'b1;
          wait_cnt = next_req.gap;
        end
        if (have_next && wait_cnt == 0) begin
          in_valid <= 1'b1;
          in_up_pressed <= next_req.up;
          in_down_pressed <= next_req.dn;
          have_next = 1'b0;
        end else begin
          in_valid <= 1'b0;
          if (have_next) wait_cnt--;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    tick_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (predicted.size() == 0) begin
          $error("unexpected result: setpoint %0d", out_setpoint);
          errors++;
        end else begin
          want = predicted.pop_front();
          if (want.changed) steps_seen++;
          if (out_setpoint !== want.setpoint) begin
            $error("setpoint: expected %0d, got %0d", want.setpoint, out_setpoint);
            errors++;
          end
          if (out_content_changed !== want.changed) begin
            $error("content_changed: expected %0b, got %0b", want.changed,
                   out_content_changed);
            errors++;
          end
          if (out_integrator_reset !== want.ireset) begin
            $error("integrator_reset: expected %0b, got %0b", want.ireset,
                   out_integrator_reset);
            errors++;
          end
          if (out_pid_off !== want.pidoff) begin
            $error("pid_off: expected %0b, got %0b", want.pidoff, out_pid_off);
            errors++;
          end
        end
        stall_left = rx_calm ? 0 : $urandom_range(0, 8);
      end
      if (rx_hold) begin
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("hold_repeat_setpoint_adjuster_unit: mismatch");
      $finish;
    end
  end

  task automatic add_tick(input bit up, input bit dn, input bit calm);
    tick_req_t t;
    t.up = up;
    t.dn = dn;
    t.gap = calm ? 4'd0 : 4'($urandom_range(0, 8));
    tick_q.push_back(t);
    reqs_queued++;
  endtask

  task automatic reg_write(input logic [2:0] idx, input int val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    load_reg(idx, DATA_W'(val));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // setpoint last, since it reloads the live setpoint
  task automatic set_regs(input int lo, input int hi, input int dly, input int stp,
                          input int init);
    reg_write(REG_SP_FLOOR, lo);
    reg_write(REG_SP_CEIL, hi);
    reg_write(REG_REPEAT_DELAY, dly);
    reg_write(REG_STEP_SIZE, stp);
    reg_write(REG_INIT_SETPOINT, init);
    settings_cnt++;
  endtask

  task automatic drain();
    while (reqs_taken != reqs_queued || predicted.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly held-button sequences, some lockouts and some noise
  task automatic add_burst(input int budget, input int dly, input bit calm);
    int n;
    int len;
    int kind;
    bit b;
    n = 0;
    while (n < budget) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        b = 1'($urandom_range(0, 1));
        len = $urandom_range(1, 3 * (dly + 2));
        for (int i = 0; i < len; i++) add_tick(b, !b, calm);
        n += len;
        // second button mid-hold forces lockout
        if (kind == 6) begin
          add_tick(1'b1, 1'b1, calm);
          add_tick(b, !b, calm);
          n += 2;
        end
        add_tick(1'b0, 1'b0, calm);
        n++;
      end else if (kind == 7) begin
        add_tick(1'b1, 1'b1, calm);
        len = $urandom_range(1, dly + 3);
        for (int i = 0; i < len; i++) add_tick(1'b1, 1'b0, calm);
        add_tick(1'b0, 1'b0, calm);
        n += len + 2;
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), calm);
        n += len;
      end
    end
  endtask

  // stimulus
  initial begin
    int dly;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: arming, both from idle, lockout, release
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b1, 1'b1, 1'b0);
    add_tick(1'b1, 1'b1, 1'b0);
    add_tick(1'b0, 1'b1, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b1, 1'b0, 1'b0);
    add_tick(1'b1, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b1, 1'b0);
    add_tick(1'b1, 1'b1, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    drain();

    // zero delay, largest step: up saturates at the ceiling, then down steps
    set_regs(0, 1023, 0, 127, 1000);
    for (int i = 0; i < 4; i++) add_tick(1'b1, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) add_tick(1'b0, 1'b1, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: dly = 1;
        1: dly = 0;
        2: dly = 255;
        default: dly = $urandom_range(0, 6);
      endcase
      case (p)
        0: set_regs(0, 1023, dly, 1, 0);
        1: set_regs(1023, 0, dly, 0, 512);
        2: set_regs($urandom_range(0, 300), $urandom_range(700, 1023), dly, 127,
                    $urandom_range(0, 1023));
        default: set_regs($urandom_range(0, 1023), $urandom_range(0, 1023), dly,
                          $urandom_range(0, 127), $urandom_range(0, 1023));
      endcase
      rx_calm = (p == 3 || p == 4);
      if (p == 4) hold_go = 1'b1;
      if (p == 2) begin
        // hold long enough for the longest delay to run out
        for (int i = 0; i < 262; i++) add_tick(1'b1, 1'b0, 1'b0);
        add_tick(1'b0, 1'b0, 1'b0);
        for (int i = 0; i < 3; i++) add_tick(1'b0, 1'b1, 1'b0);
        add_tick(1'b0, 1'b0, 1'b0);
      end else begin
        add_burst(30, dly, p == 3 || p == 4);
      end
      drain();
    end

    $display("%0d button ticks checked over %0d register settings", results_seen,
             settings_cnt);
    $display("%0d of them were setpoint steps", steps_seen);
    if (errors == 0) $display("hold_repeat_setpoint_adjuster_unit: match");
    else $display("hold_repeat_setpoint_adjuster_unit: mismatch");
    $finish;
  end

endmodule

// File: files.f
rtl/hrsa_pkg.sv
rtl/hold_repeat_setpoint_adjuster_unit.sv
sim/hold_repeat_setpoint_adjuster_unit_test.sv
